FILE: src/rpa_pkg.sv
// Shared constants, codes and types for the register pool allocator.
package rpa_pkg;

  localparam int POOL_SIZE  = 12;
  localparam int SAVE_DEPTH = 8;
  localparam int TAG_BITS   = 16;

  localparam int FUNC_W  = 3;
  localparam int INDEX_W = 4;
  localparam int ID_W    = 16;
  localparam int STAT_W  = 3;

  localparam int IN_BITS  = FUNC_W + INDEX_W + ID_W;
  localparam int IN_W     = ((IN_BITS + 7) / 8) * 8;
  localparam int OUT_BITS = 1 + INDEX_W + STAT_W;
  localparam int OUT_W    = ((OUT_BITS + 7) / 8) * 8;

  localparam int IDX_W        = $clog2(POOL_SIZE);
  localparam int CNT_W        = $clog2(POOL_SIZE + 1);
  localparam int LVL_W        = $clog2(SAVE_DEPTH + 1);
  localparam int SD_W         = (SAVE_DEPTH > 1) ? $clog2(SAVE_DEPTH) : 1;
  localparam int SAVE_ENTRIES = SAVE_DEPTH * POOL_SIZE;
  localparam int SAVE_AW      = $clog2(SAVE_ENTRIES);

  localparam logic [FUNC_W-1:0] FUNC_ALLOC_TEMP = 3'd0;
  localparam logic [FUNC_W-1:0] FUNC_ALLOC_VAR  = 3'd1;
  localparam logic [FUNC_W-1:0] FUNC_FREE       = 3'd2;
  localparam logic [FUNC_W-1:0] FUNC_FREE_TEMP  = 3'd3;
  localparam logic [FUNC_W-1:0] FUNC_LOOKUP     = 3'd4;
  localparam logic [FUNC_W-1:0] FUNC_FREE_ALL   = 3'd5;
  localparam logic [FUNC_W-1:0] FUNC_SAVE       = 3'd6;
  localparam logic [FUNC_W-1:0] FUNC_RESTORE    = 3'd7;

  localparam logic [STAT_W-1:0] STATUS_OK          = 3'd0;
  localparam logic [STAT_W-1:0] STATUS_NO_FREE     = 3'd1;
  localparam logic [STAT_W-1:0] STATUS_NOT_FOUND   = 3'd2;
  localparam logic [STAT_W-1:0] STATUS_STACK_FULL  = 3'd3;
  localparam logic [STAT_W-1:0] STATUS_STACK_EMPTY = 3'd4;

  typedef enum logic [2:0] {
    S_IDLE,
    S_CHECK,
    S_SCAN,
    S_SAVE,
    S_RESTORE,
    S_DONE
  } state_t;

endpackage

FILE: src/rpa_ram.sv
// Generic single-write, single-read RAM with registered read data.
module rpa_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

FILE: src/register_pool_allocator.sv
// Register pool allocator: free mask, tag RAM and snapshot stack RAM.
// Alloc, free and free all finish from the idle state; free if temp on an index in the pool
// first reads the tag RAM in a check state; lookup, save and restore step the tag RAM
// or snapshot RAM one entry a cycle, over up to POOL_SIZE entries.
// One item at a time: tready is high only in idle, so a new item waits until the result is loaded.
// Synchronous reset: every register free, all tags invalid (read as zero), snapshot stack empty.
module register_pool_allocator (
  input  logic                     clk,
  input  logic                     rst,
  input  logic                     s_tvalid,
  output logic                     s_tready,
  input  logic [rpa_pkg::IN_W-1:0] s_tdata,  // func[2:0], reg_index[6:3], var_id[22:7]
  output logic                     m_tvalid,
  input  logic                     m_tready,
  output logic [rpa_pkg::OUT_W-1:0] m_tdata  // found[0], out_index[4:1], status[7:5]
);

  rpa_pkg::state_t state, state_next;

  logic [rpa_pkg::FUNC_W-1:0]  in_func;
  logic [rpa_pkg::INDEX_W-1:0] in_index;
  logic [rpa_pkg::TAG_BITS-1:0] in_tag;
  logic                        in_range;
  logic [rpa_pkg::IDX_W-1:0]   in_idx;
  logic                        s_accept;
  logic                        m_load;

  logic [rpa_pkg::POOL_SIZE-1:0] free_mask;
  logic [rpa_pkg::POOL_SIZE-1:0] tag_valid;
  logic [rpa_pkg::POOL_SIZE-1:0] saved_free [rpa_pkg::SAVE_DEPTH];
  logic [rpa_pkg::LVL_W-1:0]     level;
  logic [rpa_pkg::SAVE_AW-1:0]   base;
  logic [rpa_pkg::TAG_BITS-1:0]  op_id;
  logic [rpa_pkg::CNT_W-1:0]     cnt;
  logic                          rd_pend;
  logic [rpa_pkg::IDX_W-1:0]     rd_addr_q;

  logic                          res_found;
  logic [rpa_pkg::INDEX_W-1:0]   res_index;
  logic [rpa_pkg::STAT_W-1:0]    res_status;

  logic                          lf_hit;
  logic [rpa_pkg::IDX_W-1:0]     lf_idx;
  logic                          cnt_issue;
  logic                          rd_last;
  logic [rpa_pkg::TAG_BITS-1:0]  tag_seen;
  logic                          scan_hit;

  logic                          tag_we;
  logic [rpa_pkg::IDX_W-1:0]     tag_waddr;
  logic [rpa_pkg::TAG_BITS-1:0]  tag_wdata;
  logic [rpa_pkg::IDX_W-1:0]     tag_raddr;
  logic [rpa_pkg::TAG_BITS-1:0]  tag_rdata;
  logic                          sv_we;
  logic [rpa_pkg::SAVE_AW-1:0]   sv_waddr;
  logic [rpa_pkg::SAVE_AW-1:0]   sv_raddr;
  logic [rpa_pkg::TAG_BITS-1:0]  sv_rdata;

  assign in_func  = s_tdata[rpa_pkg::FUNC_W-1:0];
  assign in_index = s_tdata[rpa_pkg::FUNC_W +: rpa_pkg::INDEX_W];
  assign in_tag   = rpa_pkg::TAG_BITS'(s_tdata[rpa_pkg::FUNC_W + rpa_pkg::INDEX_W +: rpa_pkg::ID_W]);
  assign in_range = 32'(in_index) < rpa_pkg::POOL_SIZE;
  assign in_idx   = rpa_pkg::IDX_W'(in_index);

  assign s_tready = (state == rpa_pkg::S_IDLE);
  assign s_accept = s_tvalid && s_tready;
  assign m_load   = (state == rpa_pkg::S_DONE) && (!m_tvalid || m_tready);

  assign cnt_issue = cnt < rpa_pkg::CNT_W'(rpa_pkg::POOL_SIZE);
  assign rd_last   = rd_pend && (rd_addr_q == rpa_pkg::IDX_W'(rpa_pkg::POOL_SIZE - 1));
  assign tag_seen  = tag_valid[rd_addr_q] ? tag_rdata : '0;
  assign scan_hit  = rd_pend && (tag_seen == op_id);

  always_comb begin
    lf_hit = |free_mask;
    lf_idx = '0;
    for (int i = rpa_pkg::POOL_SIZE - 1; i >= 0; i--) begin
      if (free_mask[i]) begin
        lf_idx = rpa_pkg::IDX_W'(i);
      end
    end
  end

  always_comb begin
    state_next = state;
    case (state)
      rpa_pkg::S_IDLE: begin
        if (s_accept) begin
          case (in_func)
            rpa_pkg::FUNC_FREE_TEMP: begin
              state_next = in_range ? rpa_pkg::S_CHECK : rpa_pkg::S_DONE;
            end
            rpa_pkg::FUNC_LOOKUP: state_next = rpa_pkg::S_SCAN;
            rpa_pkg::FUNC_SAVE: begin
              state_next = (32'(level) >= rpa_pkg::SAVE_DEPTH) ? rpa_pkg::S_DONE
                                                               : rpa_pkg::S_SAVE;
            end
            rpa_pkg::FUNC_RESTORE: begin
              state_next = (level == '0) ? rpa_pkg::S_DONE : rpa_pkg::S_RESTORE;
            end
            default: state_next = rpa_pkg::S_DONE;
          endcase
        end
      end
      rpa_pkg::S_CHECK: state_next = rpa_pkg::S_DONE;
      rpa_pkg::S_SCAN: begin
        if (scan_hit || rd_last) begin
          state_next = rpa_pkg::S_DONE;
        end
      end
      rpa_pkg::S_SAVE, rpa_pkg::S_RESTORE: begin
        if (rd_last) begin
          state_next = rpa_pkg::S_DONE;
        end
      end
      rpa_pkg::S_DONE: begin
        if (m_load) begin
          state_next = rpa_pkg::S_IDLE;
        end
      end
      default: state_next = rpa_pkg::S_IDLE;
    endcase
  end

  always_comb begin
    tag_we    = 1'b0;
    tag_waddr = rd_addr_q;
    tag_wdata = sv_rdata;
    tag_raddr = (state == rpa_pkg::S_IDLE) ? in_idx : rpa_pkg::IDX_W'(cnt);
    sv_we     = 1'b0;
    sv_waddr  = base + rpa_pkg::SAVE_AW'(rd_addr_q);
    sv_raddr  = base + rpa_pkg::SAVE_AW'(cnt);
    case (state)
      rpa_pkg::S_IDLE: begin
        if (s_accept && lf_hit &&
            (in_func == rpa_pkg::FUNC_ALLOC_TEMP || in_func == rpa_pkg::FUNC_ALLOC_VAR)) begin
          tag_we    = 1'b1;
          tag_waddr = lf_idx;
          tag_wdata = (in_func == rpa_pkg::FUNC_ALLOC_VAR) ? in_tag : '0;
        end
      end
      rpa_pkg::S_SAVE:    sv_we  = rd_pend;
      rpa_pkg::S_RESTORE: tag_we = rd_pend;
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= rpa_pkg::S_IDLE;
      free_mask <= '1;
      tag_valid <= '0;
      level     <= '0;
      rd_pend   <= 1'b0;
      m_tvalid  <= 1'b0;
    end else begin
      state   <= state_next;
      rd_pend <= 1'b0;
      if ((state == rpa_pkg::S_SCAN || state == rpa_pkg::S_SAVE ||
           state == rpa_pkg::S_RESTORE) && cnt_issue) begin
        cnt       <= cnt + 1'b1;
        rd_addr_q <= rpa_pkg::IDX_W'(cnt);
        rd_pend   <= 1'b1;
      end
      if (m_load) begin
        m_tvalid <= 1'b1;
        m_tdata  <= rpa_pkg::OUT_W'({res_status, res_index, res_found});
      end else if (m_tready) begin
        m_tvalid <= 1'b0;
      end
      case (state)
        rpa_pkg::S_IDLE: begin
          if (s_accept) begin
            cnt        <= '0;
            rd_addr_q  <= in_idx;
            op_id      <= in_tag;
            res_found  <= 1'b0;
            res_index  <= '0;
            res_status <= rpa_pkg::STATUS_OK;
            case (in_func)
              rpa_pkg::FUNC_ALLOC_TEMP, rpa_pkg::FUNC_ALLOC_VAR: begin
                if (lf_hit) begin
                  free_mask[lf_idx] <= 1'b0;
                  tag_valid[lf_idx] <= 1'b1;
                  res_found         <= 1'b1;
                  res_index         <= rpa_pkg::INDEX_W'(lf_idx);
                end else begin
                  res_status <= rpa_pkg::STATUS_NO_FREE;
                end
              end
              rpa_pkg::FUNC_FREE, rpa_pkg::FUNC_FREE_TEMP: begin
                if (!in_range) begin
                  res_status <= rpa_pkg::STATUS_NOT_FOUND;
                end else if (in_func == rpa_pkg::FUNC_FREE) begin
                  free_mask[in_idx] <= 1'b1;
                  tag_valid[in_idx] <= 1'b0;
                  res_found         <= 1'b1;
                end
              end
              rpa_pkg::FUNC_LOOKUP: res_status <= rpa_pkg::STATUS_NOT_FOUND;
              rpa_pkg::FUNC_FREE_ALL: begin
                free_mask <= '1;
                tag_valid <= '0;
                res_found <= 1'b1;
              end
              rpa_pkg::FUNC_SAVE: begin
                if (32'(level) >= rpa_pkg::SAVE_DEPTH) begin
                  res_status <= rpa_pkg::STATUS_STACK_FULL;
                end else begin
                  base <= rpa_pkg::SAVE_AW'(32'(level) * rpa_pkg::POOL_SIZE);
                end
              end
              rpa_pkg::FUNC_RESTORE: begin
                if (level == '0) begin
                  res_status <= rpa_pkg::STATUS_STACK_EMPTY;
                end else begin
                  level <= level - 1'b1;
                  base  <= rpa_pkg::SAVE_AW'((32'(level) - 1) * rpa_pkg::POOL_SIZE);
                end
              end
              default: begin
              end
            endcase
          end
        end
        rpa_pkg::S_CHECK: begin
          if (tag_seen == '0) begin
            free_mask[rd_addr_q] <= 1'b1;
            tag_valid[rd_addr_q] <= 1'b0;
            res_found            <= 1'b1;
          end
        end
        rpa_pkg::S_SCAN: begin
          if (scan_hit) begin
            res_found  <= 1'b1;
            res_index  <= rpa_pkg::INDEX_W'(rd_addr_q);
            res_status <= rpa_pkg::STATUS_OK;
          end
        end
        rpa_pkg::S_SAVE: begin
          if (rd_last) begin
            saved_free[level[rpa_pkg::SD_W-1:0]] <= free_mask;
            level     <= level + 1'b1;
            free_mask <= '1;
            tag_valid <= '0;
            res_found <= 1'b1;
          end
        end
        rpa_pkg::S_RESTORE: begin
          if (rd_pend) begin
            tag_valid[rd_addr_q] <= 1'b1;
          end
          if (rd_last) begin
            free_mask <= saved_free[level[rpa_pkg::SD_W-1:0]];
            res_found <= 1'b1;
          end
        end
        default: begin
        end
      endcase
    end
  end

  rpa_ram #(
    .WIDTH(rpa_pkg::TAG_BITS),
    .DEPTH(rpa_pkg::POOL_SIZE)
  ) u_tag_ram (
    .clk  (clk),
    .we   (tag_we),
    .waddr(tag_waddr),
    .wdata(tag_wdata),
    .raddr(tag_raddr),
    .rdata(tag_rdata)
  );

  rpa_ram #(
    .WIDTH(rpa_pkg::TAG_BITS),
    .DEPTH(rpa_pkg::SAVE_ENTRIES)
  ) u_save_ram (
    .clk  (clk),
    .we   (sv_we),
    .waddr(sv_waddr),
    .wdata(tag_seen),
    .raddr(sv_raddr),
    .rdata(sv_rdata)
  );

endmodule

FILE: src/rpa_checker.sv
// Port-level checks for the register pool allocator, bound to the top level.
module rpa_checker (
  input logic                      clk,
  input logic                      rst,
  input logic                      s_tvalid,
  input logic                      s_tready,
  input logic                      m_tvalid,
  input logic                      m_tready,
  input logic [rpa_pkg::OUT_W-1:0] m_tdata
);

  logic                          chk_found;
  logic [rpa_pkg::INDEX_W-1:0]   chk_index;
  logic [rpa_pkg::STAT_W-1:0]    chk_status;
  logic                          in_xfer;

  assign chk_found  = m_tdata[0];
  assign chk_index  = m_tdata[rpa_pkg::INDEX_W:1];
  assign chk_status = m_tdata[rpa_pkg::INDEX_W + rpa_pkg::STAT_W:rpa_pkg::INDEX_W + 1];
  assign in_xfer    = s_tvalid && s_tready;

  a_reset_clears_out: assert property (@(posedge clk) rst |=> !m_tvalid)
    else $error("output valid after reset");

  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
    else $error("stalled output transfer changed");

  a_found_ok: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && chk_found |-> chk_status == rpa_pkg::STATUS_OK &&
      32'(chk_index) < rpa_pkg::POOL_SIZE)
    else $error("found result with bad status or index");

  a_miss_index: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !chk_found |-> chk_index == '0)
    else $error("miss result with nonzero index");

  a_no_accept_after_input: assert property (@(posedge clk) disable iff (rst)
    in_xfer |=> !s_tready)
    else $error("input accepted while previous item in flight");

endmodule

bind register_pool_allocator rpa_checker u_rpa_checker (
  .clk     (clk),
  .rst     (rst),
  .s_tvalid(s_tvalid),
  .s_tready(s_tready),
  .m_tvalid(m_tvalid),
  .m_tready(m_tready),
  .m_tdata (m_tdata)
);

FILE: tb/sv/testbench.sv
// Testbench for the register pool allocator: directed and random operations, checked per result.
`timescale 1ns / 100ps

module testbench;

  localparam int CYCLE_LIMIT  = 500000;
  localparam int RANDOM_ITEMS = 1150;
  localparam int SETTLE_WAIT  = 40;

  typedef struct packed {
    logic                        drain_mark;
    logic [rpa_pkg::FUNC_W-1:0]  func;
    logic [rpa_pkg::INDEX_W-1:0] reg_index;
    logic [rpa_pkg::ID_W-1:0]    var_id;
  } pool_op_t;

  typedef struct packed {
    logic                        found;
    logic [rpa_pkg::INDEX_W-1:0] out_index;
    logic [rpa_pkg::STAT_W-1:0]  status;
  } pool_result_t;

  logic                      clk;
  logic                      rst = 1'b1;
  logic                      s_tvalid = 1'b0;
  logic                      s_tready;
  logic [rpa_pkg::IN_W-1:0]  s_tdata = '0;
  logic                      m_tvalid;
  logic                      m_tready = 1'b0;
  logic [rpa_pkg::OUT_W-1:0] m_tdata;

  pool_op_t     pending_ops[$];
  pool_result_t expected_results[$];
  int unsigned  errors = 0;
  int unsigned  cycle_count = 0;
  logic [rpa_pkg::ID_W-1:0] id_choices[8];

  logic [rpa_pkg::POOL_SIZE-1:0] pool_free = '1;
  logic [rpa_pkg::TAG_BITS-1:0]  pool_tag[rpa_pkg::POOL_SIZE] = '{default: '0};
  logic [rpa_pkg::POOL_SIZE-1:0] snap_free[rpa_pkg::SAVE_DEPTH];
  logic [rpa_pkg::TAG_BITS-1:0]  snap_tag[rpa_pkg::SAVE_DEPTH][rpa_pkg::POOL_SIZE];
  int unsigned                   snap_level = 0;

  register_pool_allocator u_top (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
  );

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  function automatic pool_result_t apply_op(pool_op_t op);
    pool_result_t res;
    int slot;
    res = '0;
    slot = -1;
    case (op.func)
      rpa_pkg::FUNC_ALLOC_TEMP, rpa_pkg::FUNC_ALLOC_VAR: begin
        for (int i = rpa_pkg::POOL_SIZE - 1; i >= 0; i--)
          if (pool_free[i]) slot = i;
        if (slot < 0) begin
          res.status = rpa_pkg::STATUS_NO_FREE;
        end else begin
          pool_free[slot] = 1'b0;
          pool_tag[slot] = (op.func == rpa_pkg::FUNC_ALLOC_VAR) ? op.var_id : '0;
          res.found = 1'b1;
          res.out_index = rpa_pkg::INDEX_W'(slot);
        end
      end
      rpa_pkg::FUNC_FREE, rpa_pkg::FUNC_FREE_TEMP: begin
        if (op.reg_index >= rpa_pkg::POOL_SIZE) begin
          res.status = rpa_pkg::STATUS_NOT_FOUND;
        end else if (!(op.func == rpa_pkg::FUNC_FREE_TEMP &&
                       pool_tag[op.reg_index] != '0)) begin
          pool_tag[op.reg_index] = '0;
          pool_free[op.reg_index] = 1'b1;
          res.found = 1'b1;
        end
      end
      rpa_pkg::FUNC_LOOKUP: begin
        for (int i = rpa_pkg::POOL_SIZE - 1; i >= 0; i--)
          if (pool_tag[i] == op.var_id) slot = i;
        if (slot < 0) begin
          res.status = rpa_pkg::STATUS_NOT_FOUND;
        end else begin
          res.found = 1'b1;
          res.out_index = rpa_pkg::INDEX_W'(slot);
        end
      end
      rpa_pkg::FUNC_FREE_ALL: begin
        pool_free = '1;
        pool_tag = '{default: '0};
        res.found = 1'b1;
      end
      rpa_pkg::FUNC_SAVE: begin
        if (snap_level >= rpa_pkg::SAVE_DEPTH) begin
          res.status = rpa_pkg::STATUS_STACK_FULL;
        end else begin
          snap_free[snap_level] = pool_free;
          snap_tag[snap_level] = pool_tag;
          snap_level++;
          pool_free = '1;
          pool_tag = '{default: '0};
          res.found = 1'b1;
        end
      end
      default: begin
        if (snap_level == 0) begin
          res.status = rpa_pkg::STATUS_STACK_EMPTY;
        end else begin
          snap_level--;
          pool_free = snap_free[snap_level];
          pool_tag = snap_tag[snap_level];
          res.found = 1'b1;
        end
      end
    endcase
    return res;
  endfunction

  function automatic void add_op(logic [rpa_pkg::FUNC_W-1:0] func,
                                 logic [rpa_pkg::INDEX_W-1:0] idx,
                                 logic [rpa_pkg::ID_W-1:0] id);
    pool_op_t op;
    op.drain_mark = 1'b0;
    op.func = func;
    op.reg_index = idx;
    op.var_id = id;
    pending_ops.push_back(op);
  endfunction

  function automatic logic [rpa_pkg::ID_W-1:0] pick_id();
    int unsigned r;
    r = $urandom_range(0, 9);
    if (r == 0) return '0;
    if (r <= 6) return id_choices[$urandom_range(0, 7)];
    return rpa_pkg::ID_W'($urandom);
  endfunction

  function automatic void add_random_op();
    int unsigned r;
    logic [rpa_pkg::INDEX_W-1:0] idx;
    r = $urandom_range(0, 99);
    idx = ($urandom_range(0, 7) == 0) ?
          rpa_pkg::INDEX_W'($urandom_range(12, 15)) :
          rpa_pkg::INDEX_W'($urandom_range(0, rpa_pkg::POOL_SIZE - 1));
    if (r < 14)
      add_op(rpa_pkg::FUNC_ALLOC_TEMP, rpa_pkg::INDEX_W'($urandom), rpa_pkg::ID_W'($urandom));
    else if (r < 34)
      add_op(rpa_pkg::FUNC_ALLOC_VAR, rpa_pkg::INDEX_W'($urandom), pick_id());
    else if (r < 50)
      add_op(rpa_pkg::FUNC_FREE, idx, rpa_pkg::ID_W'($urandom));
    else if (r < 62)
      add_op(rpa_pkg::FUNC_FREE_TEMP, idx, rpa_pkg::ID_W'($urandom));
    else if (r < 80)
      add_op(rpa_pkg::FUNC_LOOKUP, rpa_pkg::INDEX_W'($urandom), pick_id());
    else if (r < 83)
      add_op(rpa_pkg::FUNC_FREE_ALL, rpa_pkg::INDEX_W'($urandom), rpa_pkg::ID_W'($urandom));
    else if (r < 92)
      add_op(rpa_pkg::FUNC_SAVE, rpa_pkg::INDEX_W'($urandom), rpa_pkg::ID_W'($urandom));
    else
      add_op(rpa_pkg::FUNC_RESTORE, rpa_pkg::INDEX_W'($urandom), rpa_pkg::ID_W'($urandom));
  endfunction

  function automatic void add_drain();
    pool_op_t op;
    op = '0;
    op.drain_mark = 1'b1;
    pending_ops.push_back(op);
  endfunction

  initial begin : stimulus
    int unsigned issued;
    int unsigned run_len;
    int unsigned kind;
    id_choices[0] = 16'h0001;
    id_choices[1] = 16'hFFFF;
    id_choices[2] = 16'h8000;
    for (int i = 3; i < 8; i++) id_choices[i] = rpa_pkg::ID_W'($urandom);

    add_op(rpa_pkg::FUNC_RESTORE, 4'd0, 16'h0000);
    add_op(rpa_pkg::FUNC_ALLOC_VAR, 4'd0, 16'hFFFF);
    add_op(rpa_pkg::FUNC_ALLOC_VAR, 4'd15, 16'h0000);
    add_op(rpa_pkg::FUNC_LOOKUP, 4'd0, 16'hFFFF);
    add_op(rpa_pkg::FUNC_LOOKUP, 4'd0, 16'h0000);
    add_op(rpa_pkg::FUNC_FREE_TEMP, 4'd0, 16'h0000);
    add_op(rpa_pkg::FUNC_FREE, 4'd15, 16'h0000);
    add_op(rpa_pkg::FUNC_FREE, 4'd0, 16'h0000);
    add_op(rpa_pkg::FUNC_FREE_TEMP, 4'd1, 16'h0000);
    add_op(rpa_pkg::FUNC_SAVE, 4'd0, 16'h0000);
    for (int i = 1; i <= rpa_pkg::POOL_SIZE; i++)
      add_op(rpa_pkg::FUNC_ALLOC_VAR, 4'd0, rpa_pkg::ID_W'(i));
    add_op(rpa_pkg::FUNC_ALLOC_TEMP, 4'd0, 16'h0000);
    add_op(rpa_pkg::FUNC_LOOKUP, 4'd0, 16'h0000);
    add_op(rpa_pkg::FUNC_RESTORE, 4'd0, 16'h0000);
    add_op(rpa_pkg::FUNC_FREE_ALL, 4'd0, 16'h0000);
    add_drain();

    issued = 0;
    while (issued < RANDOM_ITEMS) begin
      kind = $urandom_range(0, 19);
      if (kind < 2) begin
        run_len = $urandom_range(rpa_pkg::POOL_SIZE + 1, rpa_pkg::POOL_SIZE + 3);
        for (int i = 0; i < run_len; i++)
          add_op($urandom_range(0, 3) == 0 ? rpa_pkg::FUNC_ALLOC_TEMP : rpa_pkg::FUNC_ALLOC_VAR,
                 rpa_pkg::INDEX_W'($urandom), pick_id());
      end else if (kind == 2) begin
        run_len = $urandom_range(rpa_pkg::SAVE_DEPTH + 1, rpa_pkg::SAVE_DEPTH + 2);
        for (int i = 0; i < run_len; i++) begin
          add_op(rpa_pkg::FUNC_ALLOC_VAR, rpa_pkg::INDEX_W'($urandom), pick_id());
          add_op(rpa_pkg::FUNC_SAVE, rpa_pkg::INDEX_W'($urandom), rpa_pkg::ID_W'($urandom));
        end
        run_len = run_len * 2;
      end else if (kind == 3) begin
        run_len = $urandom_range(rpa_pkg::SAVE_DEPTH + 1, rpa_pkg::SAVE_DEPTH + 2);
        for (int i = 0; i < run_len; i++) begin
          add_op(rpa_pkg::FUNC_RESTORE, rpa_pkg::INDEX_W'($urandom), rpa_pkg::ID_W'($urandom));
          add_op(rpa_pkg::FUNC_LOOKUP, rpa_pkg::INDEX_W'($urandom), pick_id());
        end
        run_len = run_len * 2;
      end else begin
        run_len = 8;
        for (int i = 0; i < run_len; i++) add_random_op();
        if (kind == 4) add_drain();
      end
      issued += run_len;
    end

    repeat (6) @(posedge clk);
    rst <= 1'b0;

    while (!(pending_ops.size() == 0 && !s_tvalid && expected_results.size() == 0))
      @(posedge clk);
    repeat (SETTLE_WAIT) @(posedge clk);
    if (expected_results.size() != 0) begin
      $display("%0t: %0d results never arrived", $time, expected_results.size());
      errors++;
    end
    if (errors == 0)
      $display("DONE: 0 errors");
    else
      $display("DONE: errors detected");
    $finish;
  end

  always @(posedge clk) begin : send_ops
    pool_op_t    cur_op;
    pool_op_t    next_op;
    logic        next_valid;
    int unsigned burst_left;
    int unsigned gap_left;
    next_valid = s_tvalid;
    next_op = cur_op;
    if (rst) begin
      next_valid = 1'b0;
      burst_left = 1;
      gap_left = 0;
    end else begin
      if (s_tvalid && s_tready) begin
        expected_results.push_back(apply_op(cur_op));
        next_valid = 1'b0;
      end
      if (!next_valid) begin
        if (gap_left > 0) begin
          gap_left--;
        end else if (pending_ops.size() > 0) begin
          if (pending_ops[0].drain_mark) begin
            if (expected_results.size() == 0) void'(pending_ops.pop_front());
          end else begin
            next_op = pending_ops.pop_front();
            next_valid = 1'b1;
            if (burst_left > 1) begin
              burst_left--;
            end else begin
              burst_left = $urandom_range(1, 16);
              gap_left = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 20);
            end
          end
        end
      end
    end
    cur_op = next_op;
    s_tvalid <= next_valid;
    s_tdata <= rpa_pkg::IN_W'({next_op.var_id, next_op.reg_index, next_op.func});
  end

  always @(posedge clk) begin : check_results
    pool_result_t got;
    pool_result_t want;
    logic [1:0]   stall_mode;
    if (rst) begin
      m_tready <= 1'b0;
      stall_mode = 2'd0;
    end else begin
      if (m_tvalid && m_tready) begin
        got.found = m_tdata[0];
        got.out_index = m_tdata[4:1];
        got.status = m_tdata[7:5];
        if (expected_results.size() == 0) begin
          $display("%0t: unexpected result, expected none, actual %h", $time, m_tdata);
          errors++;
        end else begin
          want = expected_results.pop_front();
          if (got.found !== want.found) begin
            $display("%0t: found mismatch, expected %0d actual %0d",
                     $time, want.found, got.found);
            errors++;
          end
          if (got.out_index !== want.out_index) begin
            $display("%0t: out_index mismatch, expected %0d actual %0d",
                     $time, want.out_index, got.out_index);
            errors++;
          end
          if (got.status !== want.status) begin
            $display("%0t: status mismatch, expected %0d actual %0d",
                     $time, want.status, got.status);
            errors++;
          end
        end
      end
      if (cycle_count[5:0] == 6'd0) stall_mode = 2'($urandom_range(0, 3));
      case (stall_mode)
        2'd0: m_tready <= 1'b1;
        2'd1: m_tready <= 1'($urandom_range(0, 1));
        2'd2: m_tready <= ($urandom_range(0, 3) == 0);
        default: m_tready <= (cycle_count[2:0] < 3'd5);
      endcase
    end
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("DONE: errors detected");
      $finish;
    end
  end

endmodule

FILE: sim.f
src/rpa_pkg.sv
src/rpa_ram.sv
src/register_pool_allocator.sv
src/rpa_checker.sv
tb/sv/testbench.sv
